// ===== src/nfr_pkg.sv =====
// Package for the notification frame reassembler: payload structs, codes and
// the constants of the frame format. Used by every module under src.
package nfr_pkg;

  // Frame format constants
  localparam logic [7:0] START_BYTE  = 8'h01;
  localparam logic [8:0] CONT_BASE   = 9'd18;
  localparam logic [8:0] CONT_STRIDE = 9'd19;
  localparam logic [7:0] MIN_INDEX   = 8'd2;
  localparam logic [4:0] POS_MAX     = 5'd31;
  localparam logic [8:0] WP_MAX      = 9'd511;
  localparam logic [7:0] CNT_MAX     = 8'd255;
  localparam logic [3:0] MAX_INDEX_RESET = 4'd14;
  localparam int unsigned QDEPTH     = 4;

  typedef enum logic [1:0] {
    ST_COMPLETE  = 2'd0,
    ST_MORE      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_START = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_START   = 2'd1,
    KIND_CONT    = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
    logic       frame_last;
    logic [7:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic       frame_done;
    status_t    status;
    logic [7:0] package_length;
    logic [7:0] received_length;
    logic [7:0] read_data;
  } out_item_t;

  // One classified request on its way from the front to the store
  typedef struct packed {
    op_t        op;
    logic [7:0] addr;
    logic [7:0] data;
    logic       frame_done;
    status_t    status;
    logic [7:0] package_length;
    logic [7:0] received_length;
  } op_rec_t;

endpackage

// ===== src/notification_frame_reassembler.sv =====
// Notification frame reassembler, top level.
// Channels: requests enter through push/full with in_item (one frame byte or
// one store read each); results leave through empty/pop with out_item, one
// result per request, in request order. max_frame_index is set through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// as the block itself does not enforce this. A request is classified as it
// is accepted, written into the queue and then moved to the output register.
// Throughput: one request per cycle while full is low. The front end updates
// the frame state in the cycle it accepts a byte; the back end does one store
// access per cycle (one write or one registered read of the single-port store).
// A four-entry queue between the two and the output register let the sides
// stall apart: with pop held low, five requests are taken before full rises.
// Reset: frame state idle, index limit 14, all store valid bits cleared at
// once, so a read of an unwritten entry returns zero; no clearing pass.
// Store contents are never cleared; a start frame drops all valid bits.
// Depends on nfr_pkg, nfr_front, nfr_queue and nfr_back.
module notification_frame_reassembler #(
  parameter int STORE_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  nfr_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output nfr_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata
);

  logic             accept;
  logic             q_empty;
  logic             q_pop;
  nfr_pkg::op_rec_t f_rec;
  nfr_pkg::op_rec_t q_rec;

  assign accept = push && !full;

  nfr_front #(
    .STORE_BYTES(STORE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .rec      (f_rec)
  );

  nfr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (accept),
    .wr_rec(f_rec),
    .full  (full),
    .rd_en (q_pop),
    .rd_rec(q_rec),
    .empty (q_empty)
  );

  nfr_back #(
    .STORE_BYTES(STORE_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_rec   (q_rec),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  // A waiting request moves into an empty output stage at once
  a_fill_output: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && empty) |=> !empty)
    else $error("queued request did not reach the output stage");

  // A request into an idle block passes the queue and the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && q_empty && empty) |-> ##2 !empty)
    else $error("result of a request into an idle block is late");

  // Status is only reported at a frame end
  a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_item.frame_done) |-> (out_item.status == nfr_pkg::ST_COMPLETE))
    else $error("status set on a result that ended no frame");

  // The input side only reports full while requests are queued
  a_full_queued: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !q_empty)
    else $error("full raised with an empty queue");

endmodule

// ===== src/nfr_front.sv =====
// Front end of the reassembler: frame state machine and classification of
// each request into a store operation plus result fields. Uses nfr_pkg.
module nfr_front #(
  parameter int STORE_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  nfr_pkg::in_item_t  in_item,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  output nfr_pkg::op_rec_t   rec
);

  localparam logic [8:0] STORE_LIM = 9'(STORE_BYTES);

  logic [3:0]     max_index_r;
  logic           recv_r, recv_nxt;
  logic [7:0]     exp_r, exp_nxt;
  logic [7:0]     cnt_r, cnt_nxt;
  logic [4:0]     pos_r, pos_nxt;
  nfr_pkg::kind_t kind_r, kind_nxt;
  logic [8:0]     wp_r, wp_nxt;
  logic           take;
  logic [7:0]     b;

  assign b = in_item.in_byte;

  // Hold the index limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_index_r <= nfr_pkg::MAX_INDEX_RESET;
    end else if (cfg_we) begin
      max_index_r <= cfg_wdata;
    end
  end

  // Frame state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r <= 1'b0;
      exp_r  <= 8'd0;
      cnt_r  <= 8'd0;
      pos_r  <= 5'd0;
      kind_r <= nfr_pkg::KIND_NONE;
      wp_r   <= 9'd0;
    end else begin
      recv_r <= recv_nxt;
      exp_r  <= exp_nxt;
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      kind_r <= kind_nxt;
      wp_r   <= wp_nxt;
    end
  end

  // Classify the request and advance the frame state
  always_comb begin
    recv_nxt = recv_r;
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    pos_nxt  = pos_r;
    kind_nxt = kind_r;
    wp_nxt   = wp_r;
    take     = 1'b0;
    rec.op              = nfr_pkg::OP_NONE;
    rec.addr            = in_item.read_addr;
    rec.data            = b;
    rec.frame_done      = 1'b0;
    rec.status          = nfr_pkg::ST_COMPLETE;
    if (accept) begin
      if (in_item.req_type) begin
        rec.op = nfr_pkg::OP_READ;
      end else begin
        if (pos_r == 5'd0) begin
          // First byte: start marker or continuation index
          if (!recv_r) begin
            if (b == nfr_pkg::START_BYTE) begin
              kind_nxt = nfr_pkg::KIND_START;
              exp_nxt  = 8'd0;
              cnt_nxt  = 8'd0;
              wp_nxt   = 9'd0;
              rec.op   = nfr_pkg::OP_CLEAR;
            end else begin
              kind_nxt = nfr_pkg::KIND_DISCARD;
            end
          end else if (b < nfr_pkg::MIN_INDEX || b > {4'd0, max_index_r}) begin
            kind_nxt = nfr_pkg::KIND_DISCARD;
          end else begin
            kind_nxt = nfr_pkg::KIND_CONT;
            wp_nxt   = nfr_pkg::CONT_STRIDE * {5'd0, b[3:0]} - nfr_pkg::CONT_BASE
                       - 9'd2;
          end
        end else if (kind_r == nfr_pkg::KIND_START) begin
          if (pos_r == 5'd1) begin
            exp_nxt = ({1'b0, b} > STORE_LIM) ? STORE_LIM[7:0] : b;
          end else begin
            take = 1'b1;
          end
        end else if (kind_r == nfr_pkg::KIND_CONT) begin
          take = (cnt_r < exp_r);
        end

        // Store one payload byte, drop it past the store
        if (take) begin
          if (wp_r < STORE_LIM) begin
            rec.op   = nfr_pkg::OP_WRITE;
            rec.addr = wp_r[7:0];
          end
          if (wp_r != nfr_pkg::WP_MAX) begin
            wp_nxt = wp_r + 9'd1;
          end
          if (cnt_r != nfr_pkg::CNT_MAX) begin
            cnt_nxt = cnt_r + 8'd1;
          end
        end

        if (pos_r != nfr_pkg::POS_MAX) begin
          pos_nxt = pos_r + 5'd1;
        end

        // Close the frame and judge the package
        if (in_item.frame_last) begin
          rec.frame_done = 1'b1;
          if (kind_nxt == nfr_pkg::KIND_DISCARD) begin
            if (recv_r) begin
              recv_nxt   = 1'b0;
              exp_nxt    = 8'd0;
              cnt_nxt    = 8'd0;
              rec.status = nfr_pkg::ST_BAD_INDEX;
            end else begin
              rec.status = nfr_pkg::ST_NOT_START;
            end
          end else if (cnt_nxt < exp_nxt) begin
            recv_nxt   = 1'b1;
            rec.status = nfr_pkg::ST_MORE;
          end else begin
            recv_nxt   = 1'b0;
            rec.status = nfr_pkg::ST_COMPLETE;
          end
          pos_nxt  = 5'd0;
          kind_nxt = nfr_pkg::KIND_NONE;
        end
      end
    end
    rec.package_length  = exp_nxt;
    rec.received_length = cnt_nxt;
  end

endmodule

// ===== src/nfr_queue.sv =====
// Short queue of classified requests between front and back end.
// Depth from nfr_pkg::QDEPTH; uses nfr_pkg.
module nfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  nfr_pkg::op_rec_t wr_rec,
  output logic             full,
  input  logic             rd_en,
  output nfr_pkg::op_rec_t rd_rec,
  output logic             empty
);

  localparam int PW = $clog2(nfr_pkg::QDEPTH);
  localparam logic [PW:0] DEPTH_CNT = (PW + 1)'(nfr_pkg::QDEPTH);

  nfr_pkg::op_rec_t slot_r [nfr_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      count_r;

  assign full   = (count_r == DEPTH_CNT);
  assign empty  = (count_r == '0);
  assign rd_rec = slot_r[rd_ptr_r];

  // Hold the entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_rec;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/nfr_back.sv =====
// Back end of the reassembler: package store with per-entry valid bits and
// the output register stage. Uses nfr_pkg.
module nfr_back #(
  parameter int STORE_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  nfr_pkg::op_rec_t   q_rec,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output nfr_pkg::out_item_t out_item
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [8:0] STORE_LIM = 9'(STORE_BYTES);

  logic [7:0]       mem [STORE_BYTES];
  logic [STORE_BYTES-1:0] valid_r;
  logic             out_valid_r;
  nfr_pkg::op_rec_t out_rec_r;
  logic [7:0]       rd_data_r;
  logic             rd_ok_r;
  logic [AW-1:0]    idx;
  logic             in_range;

  assign idx      = q_rec.addr[AW-1:0];
  assign in_range = ({1'b0, q_rec.addr} < STORE_LIM);
  assign q_pop    = !q_empty && (!out_valid_r || pop);
  assign empty    = !out_valid_r;

  // Write and read the store
  always_ff @(posedge clk) begin
    if (q_pop && q_rec.op == nfr_pkg::OP_WRITE) begin
      mem[idx] <= q_rec.data;
    end
    if (q_pop) begin
      rd_data_r <= mem[idx];
    end
  end

  // Valid bits: drop all on a start frame, set on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (q_pop && q_rec.op == nfr_pkg::OP_CLEAR) begin
      valid_r <= '0;
    end else if (q_pop && q_rec.op == nfr_pkg::OP_WRITE) begin
      valid_r[idx] <= 1'b1;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_rec_r <= q_rec;
      rd_ok_r   <= (q_rec.op == nfr_pkg::OP_READ) && in_range && valid_r[idx];
    end
  end

  // Output stage occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Form the result
  always_comb begin
    out_item.frame_done      = out_rec_r.frame_done;
    out_item.status          = out_rec_r.status;
    out_item.package_length  = out_rec_r.package_length;
    out_item.received_length = out_rec_r.received_length;
    out_item.read_data       = rd_ok_r ? rd_data_r : 8'h00;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for notification_frame_reassembler: a directed table, then random
// packages, noise and reads; each result checked against its row or a local model.
// Depends on nfr_pkg and the RTL under src.
module testbench;

  localparam int STORE_SIZE = 256;
  localparam int LIMIT      = 2000000;
  localparam int PHASE_LEN  = 300;

  typedef struct {
    nfr_pkg::in_item_t  req;
    bit                 typed;
    nfr_pkg::out_item_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  nfr_pkg::in_item_t  in_item;
  logic               empty;
  logic               pop;
  nfr_pkg::out_item_t out_item;
  logic               cfg_we;
  logic [3:0]         cfg_wdata;

  // Model of the reassembler state
  bit             rx_busy;
  logic [7:0]     pkg_len;
  logic [7:0]     rx_count;
  logic [4:0]     frame_pos;
  nfr_pkg::kind_t frame_kind;
  logic [8:0]     wr_ptr;
  logic [7:0]     pkg_store [STORE_SIZE];
  bit             pkg_valid [STORE_SIZE];
  logic [3:0]     max_idx;

  nfr_pkg::out_item_t pending_results[$];
  dir_row_t           dir_rows[$];
  int                 errors;
  int                 results_seen;
  int                 items_sent;
  int                 cycles;
  bit                 idle_on;

  notification_frame_reassembler #(
    .STORE_BYTES(STORE_SIZE)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Store one payload byte, drop it past the end of the store
  function automatic void store_payload(logic [7:0] b);
    if (int'(wr_ptr) < STORE_SIZE) begin
      pkg_store[wr_ptr[7:0]] = b;
      pkg_valid[wr_ptr[7:0]] = 1'b1;
    end
    if (wr_ptr < nfr_pkg::WP_MAX) wr_ptr++;
    if (rx_count < nfr_pkg::CNT_MAX) rx_count++;
  endfunction

  // Advance the model by one request and return the result it gives
  function automatic nfr_pkg::out_item_t predict_result(nfr_pkg::in_item_t it);
    nfr_pkg::out_item_t r;
    logic [7:0] b;
    r = '0;
    b = it.in_byte;
    if (it.req_type) begin
      if (int'(it.read_addr) < STORE_SIZE && pkg_valid[it.read_addr])
        r.read_data = pkg_store[it.read_addr];
    end else begin
      // classify on the first byte, then take length and payload
      if (frame_pos == 5'd0) begin
        if (!rx_busy) begin
          if (b == nfr_pkg::START_BYTE) begin
            frame_kind = nfr_pkg::KIND_START;
            pkg_len    = 8'd0;
            rx_count   = 8'd0;
            wr_ptr     = 9'd0;
            foreach (pkg_valid[i]) pkg_valid[i] = 1'b0;
          end else begin
            frame_kind = nfr_pkg::KIND_DISCARD;
          end
        end else if (b < nfr_pkg::MIN_INDEX || b > {4'd0, max_idx}) begin
          frame_kind = nfr_pkg::KIND_DISCARD;
        end else begin
          frame_kind = nfr_pkg::KIND_CONT;
          wr_ptr = nfr_pkg::CONT_BASE
                   + (9'(b) - 9'(nfr_pkg::MIN_INDEX)) * nfr_pkg::CONT_STRIDE;
        end
      end else if (frame_kind == nfr_pkg::KIND_START) begin
        if (frame_pos == 5'd1)
          pkg_len = (int'(b) > STORE_SIZE) ? 8'(STORE_SIZE) : b;
        else
          store_payload(b);
      end else if (frame_kind == nfr_pkg::KIND_CONT) begin
        if (rx_count < pkg_len) store_payload(b);
      end
      if (frame_pos < nfr_pkg::POS_MAX) frame_pos++;

      // settle the frame status on its last byte
      if (it.frame_last) begin
        r.frame_done = 1'b1;
        if (frame_kind == nfr_pkg::KIND_DISCARD) begin
          if (rx_busy) begin
            rx_busy  = 1'b0;
            pkg_len  = 8'd0;
            rx_count = 8'd0;
            r.status = nfr_pkg::ST_BAD_INDEX;
          end else begin
            r.status = nfr_pkg::ST_NOT_START;
          end
        end else if (rx_count < pkg_len) begin
          rx_busy  = 1'b1;
          r.status = nfr_pkg::ST_MORE;
        end else begin
          rx_busy  = 1'b0;
          r.status = nfr_pkg::ST_COMPLETE;
        end
        frame_pos  = 5'd0;
        frame_kind = nfr_pkg::KIND_NONE;
      end
    end
    r.package_length  = pkg_len;
    r.received_length = rx_count;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_addr();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 100));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic nfr_pkg::in_item_t frame_req(logic [7:0] b, bit last);
    nfr_pkg::in_item_t it;
    it.req_type   = 1'b0;
    it.in_byte    = b;
    it.frame_last = last;
    it.read_addr  = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic nfr_pkg::in_item_t read_req(logic [7:0] addr);
    nfr_pkg::in_item_t it;
    it.req_type   = 1'b1;
    it.in_byte    = 8'($urandom_range(0, 255));
    it.frame_last = 1'($urandom_range(0, 1));
    it.read_addr  = addr;
    return it;
  endfunction

  function automatic void add_row(bit rt, logic [7:0] b, bit last, logic [7:0] addr,
                                  bit typed, bit done, nfr_pkg::status_t st,
                                  logic [7:0] plen, logic [7:0] rlen, logic [7:0] rd);
    dir_row_t row;
    row.req.req_type        = rt;
    row.req.in_byte         = b;
    row.req.frame_last      = last;
    row.req.read_addr       = addr;
    row.typed               = typed;
    row.want.frame_done     = done;
    row.want.status         = st;
    row.want.package_length = plen;
    row.want.received_length = rlen;
    row.want.read_data      = rd;
    dir_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic send_item(nfr_pkg::in_item_t it, bit typed = 1'b0,
                           nfr_pkg::out_item_t want = '0);
    nfr_pkg::out_item_t pred;
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    pred = predict_result(it);
    pending_results.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Send a frame, with the odd store read slipped in before some of its bytes
  task automatic send_frame(input logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(read_req(pick_addr()));
      send_item(frame_req(bytes[i], i == bytes.size() - 1));
    end
  endtask

  // Drop push and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Check each result taken against the oldest expectation
  always @(posedge clk) begin
    nfr_pkg::out_item_t want;
    if (rst_n && pop && !empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, out_item);
      end else begin
        want = pending_results.pop_front();
        check_field("frame_done", want.frame_done, out_item.frame_done);
        check_field("status", want.status, out_item.status);
        check_field("package_length", want.package_length, out_item.package_length);
        check_field("received_length", want.received_length, out_item.received_length);
        check_field("read_data", want.read_data, out_item.read_data);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random gaps, and one long hold-off to fill the block
  initial begin : pop_driver
    int gap_left;
    int hold_left;
    bit held;
    pop = 1'b0;
    gap_left = 0;
    hold_left = 0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        gap_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int r;
    int n;
    int idx;
    int guard;
    int start_cnt;
    logic [7:0] len;
    logic [7:0] fb[$];
    logic [3:0] cfg_plan [5];

    rst_n     = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    errors    = 0;
    results_seen = 0;
    items_sent = 0;
    cycles    = 0;
    idle_on   = 1'b1;

    // model state after reset
    rx_busy    = 1'b0;
    pkg_len    = 8'd0;
    rx_count   = 8'd0;
    frame_pos  = 5'd0;
    frame_kind = nfr_pkg::KIND_NONE;
    wr_ptr     = 9'd0;
    max_idx    = nfr_pkg::MAX_INDEX_RESET;
    foreach (pkg_valid[i]) begin
      pkg_valid[i] = 1'b0;
      pkg_store[i] = 8'd0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: reads after reset, non-start frames, short packages,
    // a continuation, bad indexes both sides of the accepted range
    add_row(1, 8'h00, 0, 8'd0,   1, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(1, 8'hFF, 1, 8'd255, 1, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'hFF, 1, 8'd0,   1, 1, nfr_pkg::ST_NOT_START, 8'd0,   8'd0, 8'd0);
    add_row(0, 8'h00, 0, 8'd255, 1, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, nfr_pkg::START_BYTE, 1, 8'd0, 1, 1, nfr_pkg::ST_NOT_START,
            8'd0, 8'd0, 8'd0);
    add_row(0, nfr_pkg::START_BYTE, 1, 8'd0, 1, 1, nfr_pkg::ST_COMPLETE,
            8'd0, 8'd0, 8'd0);
    add_row(0, nfr_pkg::START_BYTE, 0, 8'd0, 0, 0, nfr_pkg::ST_COMPLETE,
            8'd0, 8'd0, 8'd0);
    add_row(0, 8'd38, 0, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'h00, 0, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'hFF, 0, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'h5A, 1, 8'd0,   1, 1, nfr_pkg::ST_MORE,      8'd38,  8'd3, 8'd0);
    add_row(1, 8'h00, 0, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(1, 8'h00, 0, 8'd1,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'd2,  0, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'h81, 1, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'd15, 1, 8'd0,   1, 1, nfr_pkg::ST_BAD_INDEX, 8'd0,   8'd0, 8'd0);
    add_row(1, 8'h00, 0, 8'd18,  0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, nfr_pkg::START_BYTE, 0, 8'd0, 0, 0, nfr_pkg::ST_COMPLETE,
            8'd0, 8'd0, 8'd0);
    add_row(0, 8'd2,  0, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'hAA, 0, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'h55, 1, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, nfr_pkg::START_BYTE, 0, 8'd0, 0, 0, nfr_pkg::ST_COMPLETE,
            8'd0, 8'd0, 8'd0);
    add_row(0, 8'hFF, 0, 8'd0,   0, 0, nfr_pkg::ST_COMPLETE,  8'd0,   8'd0, 8'd0);
    add_row(0, 8'h3C, 1, 8'd0,   1, 1, nfr_pkg::ST_MORE,      8'd255, 8'd1, 8'd0);
    add_row(0, 8'd1,  1, 8'd0,   1, 1, nfr_pkg::ST_BAD_INDEX, 8'd0,   8'd0, 8'd0);
    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    drain();

    cfg_plan[0] = 4'd15;
    cfg_plan[1] = 4'd2;
    cfg_plan[2] = 4'($urandom_range(3, 13));
    cfg_plan[3] = 4'd14;
    cfg_plan[4] = 4'($urandom_range(2, 15));

    for (int ph = 0; ph < 5; ph++) begin
      // set the index limit while nothing is in flight
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= cfg_plan[ph];
      max_idx    = cfg_plan[ph];
      @(negedge clk);
      cfg_we    <= 1'b0;
      idle_on    = (ph != 2);

      // one oversized start frame: saturates count, pointer and position
      if (ph == 0) begin
        fb = {nfr_pkg::START_BYTE, 8'd200};
        repeat (530) fb.push_back(8'($urandom_range(0, 255)));
        send_frame(fb);
      end

      start_cnt = items_sent;
      while (items_sent - start_cnt < PHASE_LEN) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // mostly well-formed package: start frame, then indexed continuations
          fb = {nfr_pkg::START_BYTE};
          if ($urandom_range(0, 19) != 0) begin
            n = $urandom_range(0, 99);
            if (n < 8)       len = 8'd0;
            else if (n < 16) len = 8'd255;
            else if (n < 24) len = 8'($urandom_range(0, 255));
            else             len = 8'($urandom_range(1, 70));
            fb.push_back(len);
            repeat ($urandom_range(0, 18)) fb.push_back(8'($urandom_range(0, 255)));
          end
          send_frame(fb);
          idx = 2;
          guard = 0;
          while (rx_busy && guard < 16 && $urandom_range(0, 19) != 0) begin
            n = $urandom_range(0, 99);
            if (n < 6)       fb = {8'($urandom_range(0, 1))};
            else if (n < 10) fb = {8'($urandom_range(0, 255))};
            else begin
              fb = {8'(idx)};
              idx++;
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 19;
            repeat (n) fb.push_back(8'($urandom_range(0, 255)));
            send_frame(fb);
            guard++;
          end
        end else if (r < 82) begin
          repeat ($urandom_range(1, 6)) send_item(read_req(pick_addr()));
        end else begin
          // noise frame, whatever state the block is in
          fb.delete();
          repeat ($urandom_range(1, 8)) fb.push_back(8'($urandom_range(0, 255)));
          send_frame(fb);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
